>>> hw/rtl/lcsl_pkg.sv
// ============================================================================
// lcsl_pkg
// Shared types and constants of the longest common subsequence length core.
// ============================================================================
package lcsl_pkg;

    // Byte width of both strings.
    localparam int unsigned SYM_W = 8;

    // Width of the reported result.
    localparam int unsigned RES_W = 10;

    // Width of lengths and row values carried along the cell chain. It covers
    // the largest supported reference of 4096 symbols.
    localparam int unsigned LEN_W = 13;

    // One second-string byte travelling down the chain. The up and diag
    // fields carry the previous cell's new and old row values; len is the
    // reference length seen when the byte entered.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [SYM_W-1:0] symbol;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] up;
        logic [LEN_W-1:0] diag;
    } lcsl_token_t;

    // Broadcast that loads one reference byte into the cell at index.
    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] index;
        logic [SYM_W-1:0] symbol;
    } lcsl_load_t;

endpackage

>>> hw/rtl/lcsl_item_if.sv
// ============================================================================
// lcsl_item_if
// Input channel: one byte of either string per transfer.
// ============================================================================
interface lcsl_item_if;

    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [lcsl_pkg::SYM_W-1:0] symbol;
    logic                      last;

    modport source (output valid, output mode, output symbol, output last, input ready);
    modport sink (input valid, input mode, input symbol, input last, output ready);

endinterface

>>> hw/rtl/lcsl_result_if.sv
// ============================================================================
// lcsl_result_if
// Output channel: one subsequence length and overflow flag per transfer.
// ============================================================================
interface lcsl_result_if;

    logic                      valid;
    logic                      ready;
    logic [lcsl_pkg::RES_W-1:0] lcs_length;
    logic                      overflow;

    modport source (output valid, output lcs_length, output overflow, input ready);
    modport sink (input valid, input lcs_length, input overflow, output ready);

endinterface

>>> hw/rtl/longest_common_subsequence_length_core.sv
// ============================================================================
// longest_common_subsequence_length_core
// Longest common subsequence length of two byte strings on a systolic chain.
// ============================================================================
// Mode-0 transfers append bytes of the first string, one to a cell, to a
// chain of MAX_LEN cells; bytes beyond MAX_LEN are dropped and flagged as
// overflow. Mode-1 transfers carry bytes of the second string, and one is
// accepted every cycle unless a drain holds it off: each byte walks down
// the chain one cell per cycle, updating that cell's row value as it passes.
// A byte marked last emits its result once it has left the end of the chain;
// the input is held off from that transfer until the result has been taken,
// after which a new problem starts with an empty first string.
module longest_common_subsequence_length_core #(
    parameter int MAX_LEN = 512
) (
    input logic            clk,
    input logic            rst_n,
    lcsl_item_if.sink      item,
    lcsl_result_if.source  result
);

    localparam int unsigned LW    = lcsl_pkg::LEN_W;
    localparam int unsigned RW    = lcsl_pkg::RES_W;
    localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_LEN);

    logic [CNT_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic             pend_ovf_reg, pend_ovf_next;
    logic             draining_reg, draining_next;
    logic             res_valid_reg, res_valid_next;
    logic [RW-1:0]    res_len_reg, res_len_next;
    logic             res_ovf_reg, res_ovf_next;

    logic                  item_acc;
    logic                  res_take;
    logic                  last_acc;
    logic                  tail_done;
    lcsl_pkg::lcsl_load_t  load;
    lcsl_pkg::lcsl_token_t chain [MAX_LEN+1];

    // Handshake.
    assign item.ready = !draining_reg;
    assign item_acc   = item.valid && item.ready;
    assign res_take   = result.valid && result.ready;
    assign last_acc   = item_acc && item.mode && item.last;

    // Reference load broadcast and token injection into the first cell.
    always_comb
    begin
        load.valid  = item_acc && !item.mode && (len_reg < CAP);
        load.index  = LW'(len_reg);
        load.symbol = item.symbol;

        chain[0].valid  = item_acc && item.mode;
        chain[0].last   = item.last;
        chain[0].symbol = item.symbol;
        chain[0].len    = LW'(len_reg);
        chain[0].up     = '0;
        chain[0].diag   = '0;
    end

    // Cell chain.
    for (genvar g = 0; g < MAX_LEN; g++)
    begin : g_cell
        lcsl_cell #(
            .INDEX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .load    (load),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    // The up value leaving the chain is the last active cell's value, or
    // zero for an empty reference.
    assign tail_done = chain[MAX_LEN].valid && chain[MAX_LEN].last;

    // Problem state and result register.
    always_comb
    begin
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        pend_ovf_next  = pend_ovf_reg;
        draining_next  = draining_reg;
        res_valid_next = res_valid_reg;
        res_len_next   = res_len_reg;
        res_ovf_next   = res_ovf_reg;

        if (item_acc && !item.mode)
        begin
            if (len_reg < CAP)
            begin
                len_next = len_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (last_acc)
        begin
            pend_ovf_next = ovf_reg;
            ovf_next      = 1'b0;
            len_next      = '0;
            draining_next = 1'b1;
        end
        if (tail_done)
        begin
            res_valid_next = 1'b1;
            res_len_next   = chain[MAX_LEN].up[RW-1:0];
            res_ovf_next   = pend_ovf_reg;
        end
        else if (res_take)
        begin
            res_valid_next = 1'b0;
            draining_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            pend_ovf_reg  <= 1'b0;
            draining_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            pend_ovf_reg  <= pend_ovf_next;
            draining_reg  <= draining_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_len_reg <= res_len_next;
        res_ovf_reg <= res_ovf_next;
    end

    assign result.valid      = res_valid_reg;
    assign result.lcs_length = res_len_reg;
    assign result.overflow   = res_ovf_reg;

    // A pending result only exists while a problem is draining.
    a_result_in_drain : assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid |-> draining_reg
    ) else $error("result valid outside of a drain");

    // A last byte starts a drain with an empty reference.
    a_last_clears : assert property (
        @(posedge clk) disable iff (!rst_n)
        last_acc |=> (draining_reg && (len_reg == '0) && !ovf_reg)
    ) else $error("last byte did not clear the problem");

    // The reference never grows past the chain.
    a_len_bound : assert property (
        @(posedge clk) disable iff (!rst_n)
        len_reg <= CAP
    ) else $error("reference length beyond capacity");

    // A last token leaving the chain always presents a result.
    a_tail_result : assert property (
        @(posedge clk) disable iff (!rst_n)
        tail_done |=> result.valid
    ) else $error("finished token produced no result");

endmodule

>>> hw/rtl/lcsl_cell.sv
// ============================================================================
// lcsl_cell
// One reference position: holds its byte and row value, and updates the row
// value as each second-string byte passes on its way down the chain.
// ============================================================================
module lcsl_cell #(
    parameter int INDEX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcsl_pkg::lcsl_load_t  load,
    input  lcsl_pkg::lcsl_token_t tok_in,
    output lcsl_pkg::lcsl_token_t tok_out
);

    localparam int unsigned LW = lcsl_pkg::LEN_W;
    localparam logic [LW-1:0] CELL_IDX = LW'(INDEX);

    logic [lcsl_pkg::SYM_W-1:0] char_reg, char_next;
    logic [LW-1:0]              row_reg, row_next;
    lcsl_pkg::lcsl_token_t      tok_reg, tok_next;

    logic          load_hit;
    logic          active;
    logic          match;
    logic [LW-1:0] best;
    logic [LW-1:0] cell_val;

    // The cell takes part only if it lay inside the reference when the byte
    // entered the chain; otherwise the token passes through unchanged.
    always_comb
    begin
        load_hit = load.valid && (load.index == CELL_IDX);
        active   = tok_in.valid && (tok_in.len > CELL_IDX);
        match    = (char_reg == tok_in.symbol);
        best     = (row_reg > tok_in.up) ? row_reg : tok_in.up;
        cell_val = match ? (tok_in.diag + LW'(1)) : best;

        tok_next  = tok_in;
        row_next  = row_reg;
        char_next = char_reg;
        if (active)
        begin
            tok_next.up   = cell_val;
            tok_next.diag = row_reg;
            row_next      = cell_val;
        end
        // A newly appended position starts with an empty row value.
        if (load_hit)
        begin
            char_next = load.symbol;
            row_next  = '0;
        end
    end

    // Reference byte and row value.
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        row_reg  <= row_next;
    end

    // Token stage toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> sim/tb.sv
// ============================================================================
// tb
// Self-checking bench for the longest common subsequence length core.
// A short table of hand-picked transfers comes first, then a full-capacity
// reference that overflows, then randomized problems. Every accepted item
// runs through a local row-by-row dynamic-programming predictor. Each result
// transfer is checked against the oldest predicted result.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SYM_W = lcsl_pkg::SYM_W;
    localparam int unsigned RES_W = lcsl_pkg::RES_W;

    localparam int REF_CAP        = 512;
    localparam int HALF_PERIOD    = 5;
    localparam int ITEM_TARGET    = 950;
    localparam int RESULT_TARGET  = 15;
    localparam int WATCHDOG_LIMIT = 8 * REF_CAP + 1000;

    // Item modes.
    localparam bit MODE_APPEND = 1'b0;
    localparam bit MODE_MATCH  = 1'b1;

    typedef logic [RES_W-1:0] lcs_len_t;

    typedef struct packed {
        logic             mode;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } item_t;

    typedef struct packed {
        lcs_len_t lcs_length;
        logic     overflow;
    } lcs_result_t;

    typedef struct packed {
        item_t       it;
        logic        typed;
        lcs_result_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 21;

    // Hand-picked opening sequence. Rows with typed set carry a known result.
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{'{MODE_MATCH,  8'h00, 1'b1}, 1'b1, '{10'd0, 1'b0}},
        '{'{MODE_APPEND, 8'h00, 1'b0}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_APPEND, 8'hFF, 1'b1}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_APPEND, 8'h55, 1'b0}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_MATCH,  8'hFF, 1'b0}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_MATCH,  8'h00, 1'b0}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_MATCH,  8'h55, 1'b1}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_APPEND, 8'hAA, 1'b0}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_MATCH,  8'hAA, 1'b1}, 1'b1, '{10'd1, 1'b0}},
        '{'{MODE_MATCH,  8'h00, 1'b0}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_MATCH,  8'h01, 1'b1}, 1'b1, '{10'd0, 1'b0}},
        '{'{MODE_APPEND, 8'h11, 1'b0}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_MATCH,  8'h22, 1'b0}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_APPEND, 8'h22, 1'b0}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_MATCH,  8'h22, 1'b1}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_APPEND, 8'h80, 1'b0}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_MATCH,  8'h7F, 1'b1}, 1'b1, '{10'd0, 1'b0}},
        '{'{MODE_APPEND, 8'h3C, 1'b0}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_APPEND, 8'h3C, 1'b0}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_MATCH,  8'h3C, 1'b0}, 1'b0, '{10'd0, 1'b0}},
        '{'{MODE_MATCH,  8'h3C, 1'b1}, 1'b0, '{10'd0, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    lcsl_item_if   item_bus();
    lcsl_result_if result_bus();

    longest_common_subsequence_length_core #(
        .MAX_LEN (REF_CAP)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    // Predictor state: the stored first string and the current DP row.
    logic [SYM_W-1:0] first_str [REF_CAP];
    int unsigned      dp_row [REF_CAP];
    int unsigned      first_len;
    bit               first_truncated;

    lcs_result_t      lengths_due [$];
    lcs_result_t      oldest;
    logic [SYM_W-1:0] fill_bytes [REF_CAP];

    int  error_count;
    int  items_sent;
    int  results_seen;
    int  quiet_cycles;
    int  burst_left;
    bit  calm;

    always #HALF_PERIOD clk = ~clk;

    // Advance the predictor by one accepted item; flags when a result is due.
    task automatic predict_lcs(input item_t it, output bit produced, output lcs_result_t r);
        int unsigned up;
        int unsigned diag;
        int unsigned left;
        int unsigned score;
        int unsigned i;
        produced = 1'b0;
        r = '0;
        if (it.mode == MODE_APPEND)
        begin
            if (first_len < REF_CAP)
            begin
                first_str[first_len] = it.symbol;
                dp_row[first_len] = 0;
                first_len++;
            end
            else
            begin
                first_truncated = 1'b1;
            end
        end
        else
        begin
            up = 0;
            diag = 0;
            for (i = 0; i < first_len; i++)
            begin
                left = dp_row[i];
                if (first_str[i] == it.symbol)
                    score = diag + 1;
                else
                    score = (left > up) ? left : up;
                diag = left;
                up = score;
                dp_row[i] = score;
            end
            if (it.last)
            begin
                produced = 1'b1;
                r.lcs_length = (first_len > 0) ? lcs_len_t'(dp_row[first_len - 1]) : '0;
                r.overflow = first_truncated;
                for (i = 0; i < REF_CAP; i++)
                    dp_row[i] = 0;
                first_len = 0;
                first_truncated = 1'b0;
            end
        end
    endtask

    // Drive one item in bursts with random gaps; entered and left at a falling edge.
    task automatic deliver(input item_t it, input bit typed, input lcs_result_t want);
        int          gap;
        bit          produced;
        lcs_result_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_bus.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item_bus.valid  <= 1'b1;
        item_bus.mode   <= it.mode;
        item_bus.symbol <= it.symbol;
        item_bus.last   <= it.last;
        do
            @(posedge clk);
        while (!item_bus.ready);
        items_sent++;
        predict_lcs(it, produced, predicted);
        if (produced)
            lengths_due.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Hold the sender off until every predicted result has been taken.
    task automatic drain_results();
        item_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (lengths_due.size() != 0);
    endtask

    function automatic logic [SYM_W-1:0] pick_symbol(input bit narrow,
                                                     input logic [SYM_W-1:0] base);
        return narrow ? (base ^ SYM_W'($urandom_range(0, 3))) : SYM_W'($urandom);
    endfunction

    // One random problem: mostly a well-formed pair of strings, sometimes noise.
    task automatic run_random_problem();
        int               shape;
        int               n_first;
        int               n_second;
        int               k;
        bit               narrow;
        logic [SYM_W-1:0] base;
        item_t            it;
        shape  = $urandom_range(0, 99);
        narrow = ($urandom_range(0, 2) != 0);
        base   = SYM_W'($urandom);
        if (shape < 8)
        begin
            n_first = $urandom_range(1, 30);
            for (k = 0; k < n_first; k++)
            begin
                it = item_t'($urandom);
                deliver(it, 1'b0, '0);
            end
        end
        else
        begin
            if (shape < 11)
                n_first = $urandom_range(REF_CAP - 3, REF_CAP + 3);
            else if (shape < 20)
                n_first = $urandom_range(25, 120);
            else
                n_first = $urandom_range(0, 24);
            n_second = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                   : $urandom_range(1, 24);
            for (k = 0; k < n_first; k++)
            begin
                it = '{MODE_APPEND, pick_symbol(narrow, base), 1'($urandom)};
                deliver(it, 1'b0, '0);
            end
            for (k = 0; k < n_second; k++)
            begin
                // Occasionally grow the first string in the middle of the second.
                if ($urandom_range(0, 15) == 0)
                begin
                    it = '{MODE_APPEND, pick_symbol(narrow, base), 1'b0};
                    deliver(it, 1'b0, '0);
                end
                it = '{MODE_MATCH, pick_symbol(narrow, base), k == n_second - 1};
                deliver(it, 1'b0, '0);
            end
        end
    endtask

    // Result receiver: switches between stall styles every so often.
    initial
    begin
        int style;
        int hold;
        int age;
        result_bus.ready = 1'b0;
        style = 0;
        hold = 0;
        age = 0;
        forever
        begin
            @(negedge clk);
            age++;
            if (age % 97 == 0)
                style = $urandom_range(0, 3);
            if (calm)
            begin
                hold = 0;
                result_bus.ready <= 1'b1;
            end
            else if (hold > 0)
            begin
                hold--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                case (style)
                    0: result_bus.ready <= 1'b1;
                    1: result_bus.ready <= age[0];
                    2: result_bus.ready <= 1'($urandom);
                    default:
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            hold = $urandom_range(1, 40);
                            result_bus.ready <= 1'b0;
                        end
                        else
                        begin
                            result_bus.ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            results_seen++;
            if (lengths_due.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, got length %0d overflow %0b",
                         $time, result_bus.lcs_length, result_bus.overflow);
            end
            else
            begin
                oldest = lengths_due.pop_front();
                if (result_bus.lcs_length !== oldest.lcs_length)
                begin
                    error_count++;
                    $display("%0t: lcs_length mismatch, expected %0d, got %0d",
                             $time, oldest.lcs_length, result_bus.lcs_length);
                end
                if (result_bus.overflow !== oldest.overflow)
                begin
                    error_count++;
                    $display("%0t: overflow mismatch, expected %0b, got %0b",
                             $time, oldest.overflow, result_bus.overflow);
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int          k;
        int          random_items;
        int          random_results;
        int          problems;
        item_t       it;
        lcs_result_t want;

        rst_n           = 1'b0;
        item_bus.valid  = 1'b0;
        item_bus.mode   = MODE_APPEND;
        item_bus.symbol = '0;
        item_bus.last   = 1'b0;
        error_count     = 0;
        items_sent      = 0;
        results_seen    = 0;
        quiet_cycles    = 0;
        burst_left      = 0;
        calm            = 1'b0;
        first_len       = 0;
        first_truncated = 1'b0;
        for (k = 0; k < REF_CAP; k++)
        begin
            first_str[k] = '0;
            dp_row[k] = 0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table.
        for (k = 0; k < DIR_ROWS; k++)
            deliver(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].want);
        drain_results();

        // Fill the reference past capacity, then match every stored byte.
        for (k = 0; k < REF_CAP + 2; k++)
        begin
            it = '{MODE_APPEND, SYM_W'($urandom), 1'b0};
            if (k < REF_CAP)
                fill_bytes[k] = it.symbol;
            deliver(it, 1'b0, '0);
        end
        want = '{lcs_len_t'(REF_CAP), 1'b1};
        for (k = 0; k < REF_CAP; k++)
        begin
            it = '{MODE_MATCH, fill_bytes[k], k == REF_CAP - 1};
            deliver(it, k == REF_CAP - 1, want);
        end
        // The overflow flag must not survive into the next problem.
        deliver('{MODE_APPEND, 8'h5A, 1'b0}, 1'b0, '0);
        deliver('{MODE_MATCH, 8'h5A, 1'b1}, 1'b1, '{10'd1, 1'b0});
        drain_results();

        // Random problems until enough items and results have gone through.
        random_items = items_sent;
        random_results = results_seen;
        problems = 0;
        while (items_sent - random_items < ITEM_TARGET
               || results_seen - random_results < RESULT_TARGET)
        begin
            calm = ($urandom_range(0, 4) == 0);
            run_random_problem();
            problems++;
            if (problems % 8 == 0)
                drain_results();
        end
        calm = 1'b0;

        // Wait for the last results and let the chain settle.
        drain_results();
        repeat (REF_CAP + 16) @(posedge clk);
        if (lengths_due.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, lengths_due.size());
        end

        $display("Sent %0d items (%0d random problems) and checked %0d results,",
                 items_sent, problems, results_seen);
        $display("including a %0d-symbol reference with overflow; %0d mismatches.",
                 REF_CAP, error_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
